### src/button_mode_duration_setter_defines.svh
// Assertion macros shared by the checker of the mode and duration setter.
`ifndef BUTTON_MODE_DURATION_SETTER_DEFINES_SVH
`define BUTTON_MODE_DURATION_SETTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BMDS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BMDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/bmds_pkg.sv
// Package: constants, mode codes and the result layout of the mode and duration setter.
`timescale 1ns / 1ps
`default_nettype none

package bmds_pkg;

  localparam int NUM_BUTTONS = 3;

  localparam int MODE_W   = 3;
  localparam int DUR_W    = 7;
  localparam int PERIOD_W = 8;
  localparam int IN_W     = 8;
  localparam int OUT_W    = 40;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  localparam logic [MODE_W-1:0] MODE_NORMAL = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RED    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_YELLOW = 3'd3;
  localparam logic [MODE_W-1:0] MODE_GREEN  = 3'd4;

  localparam logic [PERIOD_W-1:0] REPEAT_PERIOD_RST = 8'd50;
  localparam logic [DUR_W-1:0]    MAX_DURATION_RST  = 7'd99;
  localparam logic [DUR_W-1:0]    DURATION_MIN      = 7'd1;

  // Register indexes (word address bit 2)
  localparam logic REG_REPEAT_PERIOD = 1'b0;
  localparam logic REG_MAX_DURATION  = 1'b1;

  // Result word, lowest field last
  typedef struct packed {
    logic [6:0]        pad;
    logic              edit_flag;
    logic              display_update;
    logic [DUR_W-1:0]  green_time_out;
    logic [DUR_W-1:0]  yellow_time_out;
    logic [DUR_W-1:0]  red_time_out;
    logic [DUR_W-1:0]  current_duration;
    logic [MODE_W-1:0] current_mode;
  } result_t;

endpackage

`default_nettype wire

### src/button_mode_duration_setter.sv
// Button mode and duration setter: three buttons with long-press auto-repeat, one result per tick.
//
// Takes one tick request per clock cycle while s_axis_tready is high. All per-tick work (the three
// button machines and the mode, duration and store chain, in button order 0, 1, 2) sits between
// the input handshake and the result register, so a new request can follow every such cycle. A
// result register plus one skid entry keep the input side running while the output side stalls;
// s_axis_tready drops only when both are full. The user must write repeat_period and max_duration
// through the APB port only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module button_mode_duration_setter (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // tick request
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [bmds_pkg::IN_W-1:0]   s_axis_tdata,  // [2:0] button_levels,
                                                          // [5:3] long_press_levels, [7:6] 0
  // result
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [bmds_pkg::OUT_W-1:0]       m_axis_tdata,  // [2:0] current_mode,
                                                          // [9:3] current_duration,
                                                          // [16:10] red_time_out,
                                                          // [23:17] yellow_time_out,
                                                          // [30:24] green_time_out,
                                                          // [31] display_update,
                                                          // [32] edit_flag, [39:33] 0
  // configuration
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bmds_pkg::CFG_AW-1:0] paddr,
  input  wire logic [bmds_pkg::CFG_DW-1:0] pwdata,
  output logic [bmds_pkg::CFG_DW-1:0]      prdata,
  output logic                             pready
);

  typedef enum logic [1:0] {
    PH_RELEASED = 2'd0,
    PH_PRESSED  = 2'd1,
    PH_LONG     = 2'd2
  } phase_e;

  typedef struct packed {
    phase_e                              phase;
    logic [bmds_pkg::PERIOD_W-1:0]       cnt;
    logic                                fire;
    logic                                press;
    logic                                rel;
    logic                                long_on;
  } btn_t;

  function automatic btn_t btn_next(phase_e ph, logic down, logic held,
                                    logic [bmds_pkg::PERIOD_W-1:0] cnt,
                                    logic [bmds_pkg::PERIOD_W-1:0] period);
    btn_t r;
    r.phase   = ph;
    r.cnt     = cnt;
    r.fire    = 1'b0;
    r.press   = 1'b0;
    r.rel     = 1'b0;
    r.long_on = 1'b0;
    case (ph)
      PH_PRESSED: begin
        if (!down) begin
          r.phase = PH_RELEASED;
          r.rel   = 1'b1;
        end else if (held) begin
          r.phase = PH_LONG;
          r.cnt   = '0;
        end
      end
      PH_LONG: begin
        if (!down) begin
          r.phase = PH_RELEASED;
          r.rel   = 1'b1;
        end else begin
          r.long_on = 1'b1;
          // count of 0 or 1 fires and reloads
          if (cnt <= 8'd1) begin
            r.fire = 1'b1;
            r.cnt  = period;
          end else begin
            r.cnt = cnt - 8'd1;
          end
        end
      end
      default: begin
        // long flag is ignored on the press tick itself
        r.phase = PH_RELEASED;
        if (down) begin
          r.phase = PH_PRESSED;
          r.fire  = 1'b1;
          r.press = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  // configuration
  logic [bmds_pkg::PERIOD_W-1:0] period_q;
  logic [bmds_pkg::DUR_W-1:0]    max_dur_q;
  logic                          cfg_wr;

  // state
  phase_e                        phase_q [bmds_pkg::NUM_BUTTONS];
  logic [bmds_pkg::PERIOD_W-1:0] cnt_q   [bmds_pkg::NUM_BUTTONS];
  logic [bmds_pkg::MODE_W-1:0]   mode_q, mode_d;
  logic [bmds_pkg::DUR_W-1:0]    dur_q, dur_d;
  logic                          edit_q, edit_d;
  logic [bmds_pkg::DUR_W-1:0]    red_q, red_d;
  logic [bmds_pkg::DUR_W-1:0]    yellow_q, yellow_d;
  logic [bmds_pkg::DUR_W-1:0]    green_q, green_d;

  btn_t                          btn [bmds_pkg::NUM_BUTTONS];
  logic [bmds_pkg::MODE_W-1:0]   mode_a;
  logic [bmds_pkg::DUR_W-1:0]    dur_a;
  logic [bmds_pkg::DUR_W:0]      dur_inc;
  logic                          disp;
  bmds_pkg::result_t             res;

  // output register and skid entry
  logic                          out_valid_q, out_valid_d;
  logic                          skid_valid_q, skid_valid_d;
  bmds_pkg::result_t             out_q, out_d;
  bmds_pkg::result_t             skid_q, skid_d;
  logic                          accept;
  logic                          take;

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == bmds_pkg::REG_MAX_DURATION) ?
                  {{(bmds_pkg::CFG_DW-bmds_pkg::DUR_W){1'b0}}, max_dur_q} :
                  {{(bmds_pkg::CFG_DW-bmds_pkg::PERIOD_W){1'b0}}, period_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q  <= bmds_pkg::REPEAT_PERIOD_RST;
      max_dur_q <= bmds_pkg::MAX_DURATION_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == bmds_pkg::REG_REPEAT_PERIOD) begin
        period_q <= pwdata[bmds_pkg::PERIOD_W-1:0];
      end else begin
        max_dur_q <= pwdata[bmds_pkg::DUR_W-1:0];
      end
    end
  end

  assign s_axis_tready = !skid_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign take          = out_valid_q && m_axis_tready;

  // per-button machines, independent of the mode, duration and store registers
  for (genvar g = 0; g < bmds_pkg::NUM_BUTTONS; g++) begin : g_btn
    assign btn[g] = btn_next(phase_q[g], s_axis_tdata[g], s_axis_tdata[3+g],
                             cnt_q[g], period_q);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        phase_q[g] <= PH_RELEASED;
        cnt_q[g]   <= '0;
      end else if (accept) begin
        phase_q[g] <= btn[g].phase;
        cnt_q[g]   <= btn[g].cnt;
      end
    end
  end

  // action chain: later buttons see what earlier ones set this tick
  always_comb begin
    mode_a   = mode_q;
    dur_a    = dur_q;
    edit_d   = edit_q;
    disp     = 1'b0;
    red_d    = red_q;
    yellow_d = yellow_q;
    green_d  = green_q;

    if (btn[0].rel) begin
      edit_d = 1'b0;
    end
    if (btn[0].long_on) begin
      edit_d = 1'b1;
    end
    if (btn[0].fire) begin
      disp  = 1'b1;
      dur_a = bmds_pkg::DURATION_MIN;
      if (mode_q >= bmds_pkg::MODE_GREEN) begin
        mode_a = bmds_pkg::MODE_NORMAL;
        if (btn[0].press) begin
          edit_d = 1'b1;
        end
      end else begin
        mode_a = mode_q + 3'd1;
      end
    end

    dur_inc = {1'b0, dur_a} + 8'd1;
    dur_d   = dur_a;
    if (btn[1].fire) begin
      dur_d = (dur_inc > {1'b0, max_dur_q}) ? bmds_pkg::DURATION_MIN
                                            : dur_inc[bmds_pkg::DUR_W-1:0];
    end

    if (btn[2].fire) begin
      case (mode_a)
        bmds_pkg::MODE_RED:    red_d    = dur_d;
        bmds_pkg::MODE_YELLOW: yellow_d = dur_d;
        bmds_pkg::MODE_GREEN:  green_d  = dur_d;
        default: ;
      endcase
    end
    mode_d = mode_a;

    res.pad              = '0;
    res.edit_flag        = edit_d;
    res.display_update   = disp;
    res.green_time_out   = green_d;
    res.yellow_time_out  = yellow_d;
    res.red_time_out     = red_d;
    res.current_duration = dur_d;
    res.current_mode     = mode_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= bmds_pkg::MODE_NORMAL;
      dur_q    <= bmds_pkg::DURATION_MIN;
      edit_q   <= 1'b0;
      red_q    <= '0;
      yellow_q <= '0;
      green_q  <= '0;
    end else if (accept) begin
      mode_q   <= mode_d;
      dur_q    <= dur_d;
      edit_q   <= edit_d;
      red_q    <= red_d;
      yellow_q <= yellow_d;
      green_q  <= green_d;
    end
  end

  // result register with one skid entry behind it
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (take) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = accept;
        out_d       = res;
      end
    end else if (accept) begin
      if (!out_valid_q) begin
        out_valid_d = 1'b1;
        out_d       = res;
      end else begin
        skid_valid_d = 1'b1;
        skid_d       = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

`default_nettype wire

### src/bmds_checker.sv
// Port-level checker for the mode and duration setter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "button_mode_duration_setter_defines.svh"

module bmds_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       s_axis_tready,
  input wire logic                       m_axis_tvalid,
  input wire logic                       m_axis_tready,
  input wire logic [bmds_pkg::OUT_W-1:0] m_axis_tdata
);

  bmds_pkg::result_t res;
  logic              mode_ok;
  logic              dur_ok;
  logic              disp_seen;
  logic              wrap_seen;
  logic              stalled;

  assign res       = bmds_pkg::result_t'(m_axis_tdata);
  assign mode_ok   = res.current_mode >= bmds_pkg::MODE_NORMAL &&
                     res.current_mode <= bmds_pkg::MODE_GREEN;
  // a mode step resets the duration; button 1 may step it once more in the same tick
  assign dur_ok    = res.current_duration == bmds_pkg::DURATION_MIN ||
                     res.current_duration == bmds_pkg::DURATION_MIN + 7'd1;
  assign disp_seen = m_axis_tvalid && res.display_update;
  assign wrap_seen = disp_seen && res.current_mode == bmds_pkg::MODE_NORMAL;
  assign stalled   = m_axis_tvalid && !m_axis_tready;

  `BMDS_ASSERT_NOW(a_mode_range, m_axis_tvalid, mode_ok, "mode out of range")

  `BMDS_ASSERT_NOW(a_disp_dur, disp_seen, dur_ok, "duration not reset on mode step")

  // wrapping to normal mode always leaves the edit flag set
  `BMDS_ASSERT_NOW(a_wrap_edit, wrap_seen, res.edit_flag, "edit flag clear after mode wrap")

  `BMDS_ASSERT_NOW(a_empty_ready, !m_axis_tvalid, s_axis_tready, "input stalled, output empty")

  `BMDS_ASSERT_NEXT(a_out_hold, stalled, m_axis_tvalid && $stable(m_axis_tdata), "result moved")

endmodule

bind button_mode_duration_setter bmds_checker u_bmds_checker (.*);

`default_nettype wire

### verif/tb_button_mode_duration_setter.sv
// Testbench for the button mode and duration setter: directed and random button ticks, self-checking.
`timescale 1ns / 1ps

module tb_button_mode_duration_setter;

  localparam int IDLE_LIMIT = 3000;
  localparam int NUM_PHASES = 5;

  typedef enum logic [1:0] {
    BTN_RELEASED = 2'd0,
    BTN_PRESSED  = 2'd1,
    BTN_LONG     = 2'd2
  } btn_phase_e;

  logic                        clk_i         = 1'b0;
  logic                        rst_ni        = 1'b0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [bmds_pkg::IN_W-1:0]   s_axis_tdata  = '0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [bmds_pkg::OUT_W-1:0]  m_axis_tdata;
  logic                        psel          = 1'b0;
  logic                        penable       = 1'b0;
  logic                        pwrite        = 1'b0;
  logic [bmds_pkg::CFG_AW-1:0] paddr         = '0;
  logic [bmds_pkg::CFG_DW-1:0] pwdata        = '0;
  logic [bmds_pkg::CFG_DW-1:0] prdata;
  logic                        pready;

  button_mode_duration_setter uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [2:0] button_levels, [5:3] long_press_levels, [7:6] 0
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [2:0] mode, [9:3] duration, [16:10] red,
                                     // [23:17] yellow, [30:24] green, [31] display_update,
                                     // [32] edit_flag, [39:33] 0
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #6 clk_i = ~clk_i;

  // Shadow copy of the setter state and its registers
  btn_phase_e                    btn_phase [bmds_pkg::NUM_BUTTONS];
  logic [8:0]                    rpt_cnt   [bmds_pkg::NUM_BUTTONS];
  logic [bmds_pkg::MODE_W-1:0]   mode_q;
  logic [bmds_pkg::DUR_W-1:0]    dur_q, red_q, yel_q, grn_q;
  logic                          edit_q;
  logic [bmds_pkg::PERIOD_W-1:0] period_cfg;
  logic [bmds_pkg::DUR_W-1:0]    max_dur_cfg;

  logic [5:0]        tick_q [$];        // {long_press_levels, button_levels}
  bmds_pkg::result_t setter_out_q [$];

  int mismatches    = 0;
  int results_seen  = 0;
  int send_gap      = 0;
  int recv_gap      = 0;
  int backlog_hold  = 0;
  int idle_cycles   = 0;
  int calm_left     = 0;
  logic calm        = 1'b0;
  bmds_pkg::result_t got_res, want_res;

  // Random-tick generator state per button
  int press_left [bmds_pkg::NUM_BUTTONS] = '{0, 0, 0};
  int long_wait  [bmds_pkg::NUM_BUTTONS] = '{0, 0, 0};

  int phase_period [NUM_PHASES] = '{1, 0, 255, 2, 9};
  int phase_max    [NUM_PHASES] = '{127, 0, 1, 5, 12};
  int phase_items  [NUM_PHASES] = '{250, 200, 320, 200, 180};

  // octal digits: long flags, levels
  logic [5:0] directed_ticks [24] = '{
    6'o00, 6'o70, 6'o04, 6'o00, 6'o11, 6'o11, 6'o11, 6'o00,
    6'o02, 6'o00, 6'o02, 6'o06, 6'o00, 6'o01, 6'o00, 6'o01,
    6'o00, 6'o77, 6'o77, 6'o77, 6'o07, 6'o00, 6'o07, 6'o70
  };

  // Action of one button; returns 1 when the mode wrapped
  function automatic logic button_action(input int b);
    logic [7:0] d;
    logic       wrapped;
    wrapped = 1'b0;
    case (b)
      0: begin
        wrapped = (mode_q == bmds_pkg::MODE_GREEN);
        mode_q  = wrapped ? bmds_pkg::MODE_NORMAL : mode_q + 3'd1;
        dur_q   = bmds_pkg::DURATION_MIN;
      end
      1: begin
        d     = {1'b0, dur_q} + 8'd1;
        dur_q = (d > {1'b0, max_dur_cfg}) ? bmds_pkg::DURATION_MIN : d[bmds_pkg::DUR_W-1:0];
      end
      default: begin
        case (mode_q)
          bmds_pkg::MODE_RED:    red_q = dur_q;
          bmds_pkg::MODE_YELLOW: yel_q = dur_q;
          bmds_pkg::MODE_GREEN:  grn_q = dur_q;
          default: ;
        endcase
      end
    endcase
    return wrapped;
  endfunction

  function automatic bmds_pkg::result_t advance_setter(input logic [2:0] lv,
                                                       input logic [2:0] lg);
    bmds_pkg::result_t r;
    logic              disp;
    logic              fire;
    disp = 1'b0;
    for (int i = 0; i < bmds_pkg::NUM_BUTTONS; i++) begin
      case (btn_phase[i])
        BTN_PRESSED: begin
          if (!lv[i]) begin
            btn_phase[i] = BTN_RELEASED;
            if (i == 0) edit_q = 1'b0;
          end else if (lg[i]) begin
            btn_phase[i] = BTN_LONG;
            rpt_cnt[i]   = '0;
          end
        end
        BTN_LONG: begin
          if (!lv[i]) begin
            btn_phase[i] = BTN_RELEASED;
            if (i == 0) edit_q = 1'b0;
          end else begin
            if (i == 0) edit_q = 1'b1;
            fire       = (rpt_cnt[i] <= 9'd1);
            rpt_cnt[i] = fire ? {1'b0, period_cfg} : rpt_cnt[i] - 9'd1;
            if (fire) begin
              void'(button_action(i));
              if (i == 0) disp = 1'b1;
            end
          end
        end
        default: begin
          btn_phase[i] = BTN_RELEASED;
          if (lv[i]) begin
            btn_phase[i] = BTN_PRESSED;
            if (button_action(i)) edit_q = 1'b1;
            if (i == 0) disp = 1'b1;
          end
        end
      endcase
    end
    r                  = '0;
    r.current_mode     = mode_q;
    r.current_duration = dur_q;
    r.red_time_out     = red_q;
    r.yellow_time_out  = yel_q;
    r.green_time_out   = grn_q;
    r.display_update   = disp;
    r.edit_flag        = edit_q;
    return r;
  endfunction

  // Mostly no gap, sometimes a short one, rarely a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Press episodes per button: a short tap, or a press that turns into a long hold
  task automatic queue_random(input int n);
    logic [2:0] lv, lg;
    int         span;
    span = 2 * period_cfg + 3;
    if (span < 160) span = 160;
    repeat (n) begin
      lv = '0;
      lg = '0;
      for (int b = 0; b < bmds_pkg::NUM_BUTTONS; b++) begin
        if (press_left[b] > 0) begin
          lv[b] = 1'b1;
          lg[b] = (long_wait[b] == 0);
          if (long_wait[b] > 0) long_wait[b]--;
          press_left[b]--;
        end else begin
          lg[b] = ($urandom_range(0, 99) < 4);
          if ($urandom_range(0, 99) < 20) begin
            long_wait[b]  = $urandom_range(1, 4);
            press_left[b] = $urandom_range(0, 1) ? $urandom_range(1, long_wait[b])
                                                 : long_wait[b] + $urandom_range(1, span);
          end
        end
      end
      if ($urandom_range(0, 99) < 10) begin
        lv = 3'($urandom_range(0, 7));
        lg = 3'($urandom_range(0, 7));
      end
      tick_q.push_back({lg, lv});
    end
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    while (tick_q.size() != 0 || s_axis_tvalid || setter_out_q.size() != 0) @(negedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic idx, input logic [bmds_pkg::CFG_DW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == bmds_pkg::REG_REPEAT_PERIOD) period_cfg = val[bmds_pkg::PERIOD_W-1:0];
    else max_dur_cfg = val[bmds_pkg::DUR_W-1:0];
  endtask

  task automatic check_field(input string name, input int unsigned want_v,
                             input int unsigned got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatches++;
    end
  endtask

  // Alternate stretches with and without idling
  always @(posedge clk_i) begin
    if (calm_left > 0) begin
      calm_left <= calm_left - 1;
    end else begin
      calm      <= ($urandom_range(0, 2) == 0);
      calm_left <= $urandom_range(30, 150);
    end
  end

  // Tick request driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        setter_out_q.push_back(advance_setter(s_axis_tdata[2:0], s_axis_tdata[5:3]));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0 || tick_q.size() == 0) begin
          s_axis_tvalid <= 1'b0;
          if (send_gap > 0) send_gap--;
        end else begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {2'b00, tick_q.pop_front()};
          send_gap = calm ? 0 : pick_gap();
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_res = m_axis_tdata;
        if (setter_out_q.size() == 0) begin
          $error("result with nothing pending: %h", m_axis_tdata);
          mismatches++;
        end else begin
          want_res = setter_out_q.pop_front();
          check_field("current_mode", want_res.current_mode, got_res.current_mode);
          check_field("current_duration", want_res.current_duration,
                      got_res.current_duration);
          check_field("red_time_out", want_res.red_time_out, got_res.red_time_out);
          check_field("yellow_time_out", want_res.yellow_time_out, got_res.yellow_time_out);
          check_field("green_time_out", want_res.green_time_out, got_res.green_time_out);
          check_field("display_update", want_res.display_update, got_res.display_update);
          check_field("edit_flag", want_res.edit_flag, got_res.edit_flag);
          check_field("pad", want_res.pad, got_res.pad);
        end
        results_seen++;
        // long back-pressure so the block fills and stalls its input
        if (results_seen == 400) backlog_hold = 80;
      end
      if (backlog_hold > 0) begin
        backlog_hold--;
        m_axis_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!calm && $urandom_range(0, 99) < 25) recv_gap = pick_gap();
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    for (int i = 0; i < bmds_pkg::NUM_BUTTONS; i++) begin
      btn_phase[i] = BTN_RELEASED;
      rpt_cnt[i]   = '0;
    end
    mode_q      = bmds_pkg::MODE_NORMAL;
    dur_q       = bmds_pkg::DURATION_MIN;
    edit_q      = 1'b0;
    red_q       = '0;
    yel_q       = '0;
    grn_q       = '0;
    period_cfg  = bmds_pkg::REPEAT_PERIOD_RST;
    max_dur_cfg = bmds_pkg::MAX_DURATION_RST;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_ticks[k]) tick_q.push_back(directed_ticks[k]);
    queue_random(200);

    for (int p = 0; p < NUM_PHASES; p++) begin
      // sender holds off until every result is back, then the registers change
      wait_idle();
      apb_write(bmds_pkg::REG_REPEAT_PERIOD, ($urandom & 32'hFFFF_FF00) | phase_period[p]);
      apb_write(bmds_pkg::REG_MAX_DURATION, ($urandom & 32'hFFFF_FF80) | phase_max[p]);
      queue_random(phase_items[p]);
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatches == 0 && setter_out_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
